// ===== rtl/skl_pkg.sv =====
// Shared constants, request and status codes, and control types for the sorted key list.
`timescale 1ns / 1ps
`default_nettype none
package skl_pkg;

	// Table geometry.
	localparam int CAPACITY = 16;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;

	// Request kinds.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_SEARCH = 2'd1;
	localparam logic [1:0] REQ_DELETE = 2'd2;

	// Result status codes.
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// Read address selects for the slot memory.
	localparam logic [2:0] RD_ZERO   = 3'd0;
	localparam logic [2:0] RD_CNTM1  = 3'd1;
	localparam logic [2:0] RD_PLUS1  = 3'd2;
	localparam logic [2:0] RD_PLUS2  = 3'd3;
	localparam logic [2:0] RD_MINUS2 = 3'd4;

	// Operations on the slot pointer.
	localparam logic [2:0] P_HOLD     = 3'd0;
	localparam logic [2:0] P_CLEAR    = 3'd1;
	localparam logic [2:0] P_LOAD_CNT = 3'd2;
	localparam logic [2:0] P_INC      = 3'd3;
	localparam logic [2:0] P_DEC      = 3'd4;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic [2:0] rd_sel;
		logic [2:0] p_op;
		logic       wr_en;
		logic       wr_key;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       out_load;
	} skl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [1:0] req_type;
		logic       cnt_zero;
		logic       cnt_full;
		logic       rd_lt_key;
		logic       rd_eq_key;
		logic       p_zero;
		logic       p_last;
	} skl_stat_t;

endpackage
`default_nettype wire

// ===== rtl/sorted_key_list_top.sv =====
// Top level of the sorted key list: controller and datapath.
//
// Keeps up to 16 signed 32-bit keys in ascending order, duplicates allowed.
// The input channel (in_valid, in_ready, req_type, key) takes one request
// item: insert, search or delete. The output channel (out_valid, out_ready,
// status, found, entry_count) returns exactly one result item per request.
// in_ready is high while the controller is idle; an item is then taken and
// worked on alone. A request ends early on a full insert, an empty table or
// an unused kind. An insert's work grows with the keys moved up, a search's
// with the slots compared, and a delete's with the key count; a delete on a
// full table is the longest case. An insert walks down from the top moving
// keys up, a search or delete walks up from slot 0, and a delete then moves
// the keys above the hit down. One slot is handled per cycle, which the
// single read port and single write port of the slot memory set.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, a finished result waits until the register
// frees, and no further item is taken meanwhile.
// Reset (arst_n low) empties the table at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module sorted_key_list_top (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           req_type,
	input  wire logic signed [31:0]   key,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                status,
	output logic                      found,
	output logic [4:0]                entry_count
);

	skl_pkg::skl_cmd_t  cmd;
	skl_pkg::skl_stat_t stat;
	logic [1:0]         res_status;
	logic               res_found;

	// Sequencer.
	skl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.stat       (stat),
		.cmd        (cmd),
		.res_status (res_status),
		.res_found  (res_found)
	);

	// Slot storage and result register.
	skl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_type    (req_type),
		.key         (key),
		.cmd         (cmd),
		.res_status  (res_status),
		.res_found   (res_found),
		.stat        (stat),
		.status      (status),
		.found       (found),
		.entry_count (entry_count)
	);

endmodule
`default_nettype wire

// ===== rtl/skl_dp.sv =====
// Datapath of the sorted key list: slot memory, slot pointer, count and result registers.
`timescale 1ns / 1ps
`default_nettype none
module skl_dp (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [1:0]               req_type,
	input  wire logic signed [31:0]       key,
	input  wire skl_pkg::skl_cmd_t        cmd,
	input  wire logic [1:0]               res_status,
	input  wire logic                     res_found,
	output skl_pkg::skl_stat_t            stat,
	output logic [1:0]                    status,
	output logic                          found,
	output logic [skl_pkg::CNT_W-1:0]     entry_count
);

	logic [skl_pkg::KEY_W-1:0]        mem_q [skl_pkg::CAPACITY];
	logic [skl_pkg::KEY_W-1:0]        rd_q;
	logic signed [skl_pkg::KEY_W-1:0] key_q;
	logic [1:0]                       type_q;
	logic [skl_pkg::IDX_W-1:0]        p_q;
	logic [skl_pkg::CNT_W-1:0]        cnt_q;
	logic [skl_pkg::IDX_W-1:0]        rd_addr;
	logic [skl_pkg::KEY_W-1:0]        wr_data;

	// Request capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			key_q  <= key;
		end
	end

	// Read address select.
	always_comb begin
		case (cmd.rd_sel)
			skl_pkg::RD_ZERO:   rd_addr = '0;
			skl_pkg::RD_CNTM1:  rd_addr = cnt_q[skl_pkg::IDX_W-1:0] - skl_pkg::IDX_W'(1);
			skl_pkg::RD_PLUS1:  rd_addr = p_q + skl_pkg::IDX_W'(1);
			skl_pkg::RD_PLUS2:  rd_addr = p_q + skl_pkg::IDX_W'(2);
			skl_pkg::RD_MINUS2: rd_addr = p_q - skl_pkg::IDX_W'(2);
			default:            rd_addr = '0;
		endcase
	end

	assign wr_data = cmd.wr_key ? key_q : rd_q;

	// Slot memory: one write at the pointer and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[p_q] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	// Slot pointer.
	always_ff @(posedge clk) begin
		case (cmd.p_op)
			skl_pkg::P_HOLD:     p_q <= p_q;
			skl_pkg::P_CLEAR:    p_q <= '0;
			skl_pkg::P_LOAD_CNT: p_q <= cnt_q[skl_pkg::IDX_W-1:0];
			skl_pkg::P_INC:      p_q <= p_q + skl_pkg::IDX_W'(1);
			skl_pkg::P_DEC:      p_q <= p_q - skl_pkg::IDX_W'(1);
			default:             p_q <= p_q;
		endcase
	end

	// Stored key count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + skl_pkg::CNT_W'(1);
		end else if (cmd.cnt_dec) begin
			cnt_q <= cnt_q - skl_pkg::CNT_W'(1);
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			status      <= res_status;
			found       <= res_found;
			entry_count <= cnt_q;
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.req_type  = type_q;
		stat.cnt_zero  = (cnt_q == '0);
		stat.cnt_full  = (cnt_q == skl_pkg::CNT_W'(skl_pkg::CAPACITY));
		stat.rd_lt_key = ($signed(rd_q) < key_q);
		stat.rd_eq_key = (rd_q == key_q);
		stat.p_zero    = (p_q == '0);
		stat.p_last    = ((skl_pkg::CNT_W'(p_q) + skl_pkg::CNT_W'(1)) == cnt_q);
	end

endmodule
`default_nettype wire

// ===== rtl/skl_ctrl.sv =====
// Controller of the sorted key list: request sequencing and the handshakes.
`timescale 1ns / 1ps
`default_nettype none
module skl_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire skl_pkg::skl_stat_t stat,
	output skl_pkg::skl_cmd_t       cmd,
	output logic [1:0]              res_status,
	output logic                    res_found
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_INS   = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] st_q, st_d;
	logic       fnd_q, fnd_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_free   = !out_valid_q || out_ready;
	assign res_status = st_q;
	assign res_found  = fnd_q;

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		st_d         = st_q;
		fnd_d        = fnd_q;
		cmd          = '0;
		cmd.rd_sel   = skl_pkg::RD_ZERO;
		cmd.p_op     = skl_pkg::P_HOLD;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				st_d  = skl_pkg::ST_DONE;
				fnd_d = 1'b0;
				case (stat.req_type)
					skl_pkg::REQ_INSERT: begin
						if (stat.cnt_full) begin
							st_d    = skl_pkg::ST_FULL;
							state_d = S_FIN;
						end else begin
							cmd.rd_sel = skl_pkg::RD_CNTM1;
							cmd.p_op   = skl_pkg::P_LOAD_CNT;
							state_d    = S_INS;
						end
					end
					skl_pkg::REQ_SEARCH, skl_pkg::REQ_DELETE: begin
						if (stat.cnt_zero) begin
							st_d    = skl_pkg::ST_EMPTY;
							state_d = S_FIN;
						end else begin
							cmd.rd_sel = skl_pkg::RD_ZERO;
							cmd.p_op   = skl_pkg::P_CLEAR;
							state_d    = S_SCAN;
						end
					end
					default: state_d = S_FIN;
				endcase
			end
			S_INS: begin
				// Walk down from the top, moving larger or equal keys up one slot.
				cmd.wr_en = 1'b1;
				if (stat.p_zero || stat.rd_lt_key) begin
					cmd.wr_key  = 1'b1;
					cmd.cnt_inc = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.rd_sel = skl_pkg::RD_MINUS2;
					cmd.p_op   = skl_pkg::P_DEC;
				end
			end
			S_SCAN: begin
				if (stat.rd_eq_key) begin
					fnd_d = 1'b1;
					if (stat.req_type == skl_pkg::REQ_DELETE) begin
						cmd.rd_sel = skl_pkg::RD_PLUS1;
						state_d    = S_SHIFT;
					end else begin
						state_d = S_FIN;
					end
				end else if (stat.p_last) begin
					st_d    = skl_pkg::ST_NOT_FOUND;
					state_d = S_FIN;
				end else begin
					cmd.rd_sel = skl_pkg::RD_PLUS1;
					cmd.p_op   = skl_pkg::P_INC;
				end
			end
			S_SHIFT: begin
				// Close the gap left by the removed key.
				if (stat.p_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FIN;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.rd_sel = skl_pkg::RD_PLUS2;
					cmd.p_op   = skl_pkg::P_INC;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and result code registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			st_q        <= skl_pkg::ST_DONE;
			fnd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			st_q    <= st_d;
			fnd_q   <= fnd_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/skl_checker.sv =====
// Port-level checks for the sorted key list and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module skl_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] status,
	input wire logic       found,
	input wire logic [4:0] entry_count
);

	// A stalled result item holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found)
			&& $stable(entry_count))
		else $error("result item changed while stalled");

	// The count never exceeds the capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= 5'(skl_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	// A rejected insert only happens on a full table.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == skl_pkg::ST_FULL |->
			!found && entry_count == 5'(skl_pkg::CAPACITY))
		else $error("full status with table not full");

	// An empty status only happens on an empty table.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == skl_pkg::ST_EMPTY |-> !found && entry_count == 5'd0)
		else $error("empty status with keys stored");

	// Found is only reported with a done status.
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> status == skl_pkg::ST_DONE)
		else $error("found flag with failing status");

endmodule

bind sorted_key_list_top skl_checker u_skl_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.status      (status),
	.found       (found),
	.entry_count (entry_count)
);
`default_nettype wire
